// ===== src/sss_pkg.sv =====
// shared types and constants of the servo strike sequencer
package sss_pkg;

    // sequence limits and hold time
    localparam logic [3:0]  MAX_STRIKES = 4'd12;
    localparam logic [15:0] SETTLE_MS   = 16'd100;

    // reset values of the configuration registers
    localparam logic [7:0]  LIFT_ANGLE_RST = 8'd40;
    localparam logic [7:0]  TAIL_ANGLE_RST = 8'd0;
    localparam logic [7:0]  STEP_TIME_RST  = 8'd5;
    localparam logic [15:0] PAUSE_MS_RST   = 16'd1000;

    // configuration register indexes
    localparam logic [1:0] CFG_LIFT_ANGLE = 2'd0;
    localparam logic [1:0] CFG_TAIL_ANGLE = 2'd1;
    localparam logic [1:0] CFG_STEP_TIME  = 2'd2;
    localparam logic [1:0] CFG_PAUSE_MS   = 2'd3;

    // input command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // sequencer phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_TAIL  = 5'b00010,
        PH_SWEEP = 5'b00100,
        PH_LIFT  = 5'b01000,
        PH_PAUSE = 5'b10000
    } t_phase;

    // configuration register contents
    typedef struct packed {
        logic [7:0]  lift_angle;
        logic [7:0]  tail_angle;
        logic [7:0]  step_time_ms;
        logic [15:0] pause_ms;
    } t_cfg;

    // one result transaction
    typedef struct packed {
        logic       sequence_done;
        logic [3:0] strike_number;
        logic       busy_res;
        logic       servo_enabled;
        logic [7:0] servo_angle;
    } t_result;

endpackage

// ===== src/sss_cfg_regs.sv =====
// configuration register file of the servo strike sequencer
module sss_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_wdata,
    output sss_pkg::t_cfg  o_cfg
);
    import sss_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIFT_ANGLE: n_cfg.lift_angle   = i_cfg_wdata[7:0];
                CFG_TAIL_ANGLE: n_cfg.tail_angle   = i_cfg_wdata[7:0];
                CFG_STEP_TIME:  n_cfg.step_time_ms = i_cfg_wdata[7:0];
                CFG_PAUSE_MS:   n_cfg.pause_ms     = i_cfg_wdata;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lift_angle   <= LIFT_ANGLE_RST;
            r_cfg.tail_angle   <= TAIL_ANGLE_RST;
            r_cfg.step_time_ms <= STEP_TIME_RST;
            r_cfg.pause_ms     <= PAUSE_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sss_core.sv =====
// strike sequencer state and its per-transaction update
module sss_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_command,
    input  logic [7:0]       i_strike_count,
    input  sss_pkg::t_cfg    i_cfg,
    output sss_pkg::t_result o_res
);
    import sss_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [15:0] r_wait,   n_wait;
    logic [7:0]  r_angle,  n_angle;
    logic [3:0]  r_done,   n_done;
    logic [3:0]  r_total,  n_total;
    logic        r_enable, n_enable;
    logic        n_seq_done;

    logic        expired;
    logic [15:0] wait_dec;
    logic [15:0] step_period;
    logic [7:0]  angle_step;
    logic [3:0]  done_inc;
    logic [3:0]  count_clamped;

    // counter expiry and sweep helpers
    assign expired     = (r_wait <= 16'd1);
    assign wait_dec    = r_wait - 16'd1;
    assign step_period = (i_cfg.step_time_ms == 8'd0) ? 16'd1 : {8'd0, i_cfg.step_time_ms};
    assign done_inc    = r_done + 4'd1;

    always_comb begin
        if (r_angle < i_cfg.lift_angle) begin
            angle_step = r_angle + 8'd1;
        end else if (r_angle > i_cfg.lift_angle) begin
            angle_step = r_angle - 8'd1;
        end else begin
            angle_step = r_angle;
        end
    end

    // strike count clamped to 1..max
    always_comb begin
        if (i_strike_count == 8'd0) begin
            count_clamped = 4'd1;
        end else if (i_strike_count > {4'd0, MAX_STRIKES}) begin
            count_clamped = MAX_STRIKES;
        end else begin
            count_clamped = i_strike_count[3:0];
        end
    end

    // next state for one transaction
    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_angle    = r_angle;
        n_done     = r_done;
        n_total    = r_total;
        n_enable   = r_enable;
        n_seq_done = 1'b0;
        if (i_command == CMD_START) begin
            if (r_phase == PH_IDLE) begin
                n_total  = count_clamped;
                n_done   = 4'd0;
                n_enable = 1'b1;
                n_angle  = i_cfg.tail_angle;
                n_wait   = SETTLE_MS;
                n_phase  = PH_TAIL;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_TAIL: begin
                    if (!expired) begin
                        n_wait = wait_dec;
                    end else if (r_angle == i_cfg.lift_angle) begin
                        n_wait  = SETTLE_MS;
                        n_phase = PH_LIFT;
                    end else begin
                        n_wait  = step_period;
                        n_phase = PH_SWEEP;
                    end
                end
                PH_SWEEP: begin
                    if (!expired) begin
                        n_wait = wait_dec;
                    end else begin
                        n_angle = angle_step;
                        if (angle_step == i_cfg.lift_angle) begin
                            n_wait  = SETTLE_MS;
                            n_phase = PH_LIFT;
                        end else begin
                            n_wait = step_period;
                        end
                    end
                end
                PH_LIFT: begin
                    if (!expired) begin
                        n_wait = wait_dec;
                    end else begin
                        n_enable = 1'b0;
                        n_done   = done_inc;
                        if (done_inc >= r_total) begin
                            // last strike finished
                            n_wait     = 16'd0;
                            n_phase    = PH_IDLE;
                            n_done     = 4'd0;
                            n_total    = 4'd0;
                            n_seq_done = 1'b1;
                        end else if (i_cfg.pause_ms == 16'd0) begin
                            n_enable = 1'b1;
                            n_angle  = i_cfg.tail_angle;
                            n_wait   = SETTLE_MS;
                            n_phase  = PH_TAIL;
                        end else begin
                            n_wait  = i_cfg.pause_ms;
                            n_phase = PH_PAUSE;
                        end
                    end
                end
                PH_PAUSE: begin
                    if (!expired) begin
                        n_wait = wait_dec;
                    end else begin
                        n_enable = 1'b1;
                        n_angle  = i_cfg.tail_angle;
                        n_wait   = SETTLE_MS;
                        n_phase  = PH_TAIL;
                    end
                end
                default: begin
                    n_wait  = 16'd0;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_wait   <= 16'd0;
            r_angle  <= 8'd0;
            r_done   <= 4'd0;
            r_total  <= 4'd0;
            r_enable <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_wait   <= n_wait;
            r_angle  <= n_angle;
            r_done   <= n_done;
            r_total  <= n_total;
            r_enable <= n_enable;
        end
    end

    // result describes the state after the transaction
    always_comb begin
        o_res.servo_angle   = n_angle;
        o_res.servo_enabled = n_enable;
        o_res.busy_res      = (n_phase != PH_IDLE);
        o_res.strike_number = (n_phase != PH_IDLE) ? (n_done + 4'd1) : 4'd0;
        o_res.sequence_done = n_seq_done;
    end

endmodule

// ===== src/servo_strike_sequencer.sv =====
// Servo strike sequencer: an input transaction is either a one millisecond tick
// (tuser 0) or a start request (tuser 1) carrying a strike count in tdata, and
// each one yields exactly one result transaction with the servo angle, enable,
// busy flag, strike number and a done pulse. The block takes one transaction per
// clock cycle while the result side is not stalled, since the state update is a
// single pass between the input register and the result register, which holds
// each result until it is taken. A stalled result holds the input side after
// one more transaction is buffered. Configuration writes take effect on the next
// cycle and should be made while nothing is in flight.
module servo_strike_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] strike_count
    input  logic        s_axis_tuser,   // [0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] servo_angle, [8] servo_enabled,
                                        // [9] busy_res, [13:10] strike_number,
                                        // [14] sequence_done, [15] zero
);
    import sss_pkg::*;

    t_cfg       cfg;
    t_result    core_res;
    logic       advance;

    logic       r_in_valid;
    logic       r_in_command;
    logic [7:0] r_in_count;
    logic       r_out_valid;
    t_result    r_out;

    // configuration registers
    sss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // the buffered transaction moves on when the result register is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_command <= s_axis_tuser;
            r_in_count   <= s_axis_tdata;
        end
    end

    // state update
    sss_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_command      (r_in_command),
        .i_strike_count (r_in_count),
        .i_cfg          (cfg),
        .o_res          (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.sequence_done, r_out.strike_number,
                            r_out.busy_res, r_out.servo_enabled, r_out.servo_angle};

`ifndef SYNTH
    // done pulse only ever comes with the sequence already finished
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sequence_done) |-> (!r_out.busy_res && !r_out.servo_enabled))
        else $error("done result shows a running sequence");

    // idle results carry no strike number and no enabled servo
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |->
            (r_out.strike_number == 4'd0 && !r_out.servo_enabled))
        else $error("idle result with strike number or enable");

    // a buffered transaction is kept while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_command)
            && $stable(r_in_count)))
        else $error("buffered transaction lost under stall");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the servo strike sequencer with its own strike predictor
`timescale 1ns / 100ps

module testbench;
    import sss_pkg::*;

    // cycles allowed for the two-stage pipeline to settle after the last result
    localparam int PIPE_SETTLE = 8;
    // length of the long receiver hold-off
    localparam int LONG_HOLD   = 300;
    // item budget of each random phase and the longest tick run of one sequence
    localparam int unsigned PHASE_ITEMS = 60;
    localparam int unsigned SEQ_CAP     = 210;

    // one input transaction as the driver sees it
    typedef struct packed {
        logic       command;
        logic [7:0] strike_count;
    } servo_cmd_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] strike_count
    logic        s_axis_tuser  = CMD_TICK; // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] servo_angle, [8] servo_enabled,
                                         // [9] busy_res, [13:10] strike_number,
                                         // [14] sequence_done, [15] zero

    // stimulus backlog and predicted servo states
    servo_cmd_t  cmd_backlog[$];
    t_result     pending_servo_states[$];
    logic        in_taken = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_trigger = 1'b0;
    logic        hold_seen    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned mismatch_count = 0;

    // predictor copy of the sequencer state and registers
    t_phase      seq_phase        = PH_IDLE;
    logic [15:0] hold_cnt         = '0;
    logic [7:0]  angle_now        = '0;
    logic [3:0]  strikes_finished = '0;
    logic [3:0]  strikes_wanted   = '0;
    logic        servo_attached   = 1'b0;
    t_cfg        reg_copy = '{LIFT_ANGLE_RST, TAIL_ANGLE_RST, STEP_TIME_RST, PAUSE_MS_RST};

    servo_strike_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // attach the servo and jump to the tail angle
    function automatic void start_strike();
        servo_attached = 1'b1;
        angle_now      = reg_copy.tail_angle;
        hold_cnt       = SETTLE_MS;
        seq_phase      = PH_TAIL;
    endfunction

    // count one millisecond off the hold, true once it has run out
    function automatic bit count_down();
        if (hold_cnt > 16'd1) begin
            hold_cnt = hold_cnt - 16'd1;
            return 1'b0;
        end
        hold_cnt = '0;
        return 1'b1;
    endfunction

    function automatic void start_lift_hold();
        hold_cnt  = SETTLE_MS;
        seq_phase = PH_LIFT;
    endfunction

    // a zero step time counts as one millisecond
    function automatic logic [15:0] step_reload();
        return (reg_copy.step_time_ms == '0) ? 16'd1 : {8'd0, reg_copy.step_time_ms};
    endfunction

    // advance the sequencer by one transaction and return the resulting servo state
    function automatic t_result advance_sequencer(input servo_cmd_t cmd);
        t_result    res;
        logic [7:0] n;
        res = '0;
        n   = cmd.strike_count;
        if (cmd.command == CMD_START) begin
            // a start while busy changes nothing
            if (seq_phase == PH_IDLE) begin
                if (n < 8'd1) n = 8'd1;
                if (n > MAX_STRIKES) n = {4'd0, MAX_STRIKES};
                strikes_wanted   = n[3:0];
                strikes_finished = '0;
                start_strike();
            end
        end else begin
            case (seq_phase)
                PH_TAIL: begin
                    if (count_down()) begin
                        if (angle_now == reg_copy.lift_angle) begin
                            start_lift_hold();
                        end else begin
                            hold_cnt  = step_reload();
                            seq_phase = PH_SWEEP;
                        end
                    end
                end
                PH_SWEEP: begin
                    if (count_down()) begin
                        if (angle_now < reg_copy.lift_angle) angle_now = angle_now + 8'd1;
                        else if (angle_now > reg_copy.lift_angle) angle_now = angle_now - 8'd1;
                        if (angle_now == reg_copy.lift_angle) start_lift_hold();
                        else hold_cnt = step_reload();
                    end
                end
                PH_LIFT: begin
                    if (count_down()) begin
                        servo_attached   = 1'b0;
                        strikes_finished = strikes_finished + 4'd1;
                        if (strikes_finished >= strikes_wanted) begin
                            seq_phase         = PH_IDLE;
                            strikes_finished  = '0;
                            strikes_wanted    = '0;
                            res.sequence_done = 1'b1;
                        end else if (reg_copy.pause_ms == '0) begin
                            start_strike();
                        end else begin
                            hold_cnt  = reg_copy.pause_ms;
                            seq_phase = PH_PAUSE;
                        end
                    end
                end
                PH_PAUSE: begin
                    if (count_down()) start_strike();
                end
                default: begin
                    seq_phase = PH_IDLE;
                end
            endcase
        end
        res.servo_angle   = angle_now;
        res.servo_enabled = servo_attached;
        res.busy_res      = (seq_phase != PH_IDLE);
        res.strike_number = (seq_phase != PH_IDLE) ? strikes_finished + 4'd1 : 4'd0;
        return res;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic queue_cmd(input logic command, input logic [7:0] strike_count);
        servo_cmd_t c;
        c.command      = command;
        c.strike_count = strike_count;
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_ticks(input int unsigned n);
        repeat (n) queue_cmd(CMD_TICK, 8'($urandom_range(255, 0)));
    endtask

    // register write while no transaction is in flight, mirrored into the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        case (idx)
            CFG_LIFT_ANGLE: reg_copy.lift_angle   = value[7:0];
            CFG_TAIL_ANGLE: reg_copy.tail_angle   = value[7:0];
            CFG_STEP_TIME:  reg_copy.step_time_ms = value[7:0];
            CFG_PAUSE_MS:   reg_copy.pause_ms     = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every predicted result has come back
    task automatic wait_results_drained();
        while (cmd_backlog.size() != 0 || s_axis_tvalid || pending_servo_states.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin : driver
        servo_cmd_t next_cmd;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                next_cmd = cmd_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_cmd.strike_count;
                s_axis_tuser  <= next_cmd.command;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and the long hold-off
    always @(negedge i_clk) begin : receiver
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_trigger != hold_seen) begin
            hold_seen     <= hold_trigger;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // monitor: check results first, then predict for the transaction taken at this edge
    always @(posedge i_clk) begin : monitor
        t_result    got_res;
        t_result    want_res;
        servo_cmd_t taken;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = m_axis_tdata[14:0];
            if (pending_servo_states.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata, '0);
            end else begin
                want_res = pending_servo_states.pop_front();
                if (got_res.servo_angle !== want_res.servo_angle)
                    report_mismatch("servo_angle", got_res.servo_angle, want_res.servo_angle);
                if (got_res.servo_enabled !== want_res.servo_enabled)
                    report_mismatch("servo_enabled", got_res.servo_enabled,
                                    want_res.servo_enabled);
                if (got_res.busy_res !== want_res.busy_res)
                    report_mismatch("busy_res", got_res.busy_res, want_res.busy_res);
                if (got_res.strike_number !== want_res.strike_number)
                    report_mismatch("strike_number", got_res.strike_number,
                                    want_res.strike_number);
                if (got_res.sequence_done !== want_res.sequence_done)
                    report_mismatch("sequence_done", got_res.sequence_done,
                                    want_res.sequence_done);
                if (m_axis_tdata[15] !== 1'b0)
                    report_mismatch("tdata pad bit", m_axis_tdata[15], 1'b0);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            taken.command      = s_axis_tuser;
            taken.strike_count = s_axis_tdata;
            pending_servo_states.push_back(advance_sequencer(taken));
        end
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // stimulus: directed cases, then random phases with different idling
    initial begin : stimulus
        int unsigned p, r, cnt, n, d, s, ticks, phase_items, cnt_hi;
        int unsigned lift, tail, step, pause;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_LIFT_ANGLE;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // reset settings: idle tick, zero count, start while busy, full single strike
        queue_cmd(CMD_TICK, 8'hFF);
        queue_cmd(CMD_START, 8'd0);
        queue_cmd(CMD_START, 8'd255);
        queue_ticks(2 * SETTLE_MS + 40 * 5 + 3);
        wait_results_drained();

        // equal angles above 180, zero step, zero pause between two strikes
        write_reg(CFG_LIFT_ANGLE, 16'd255);
        write_reg(CFG_TAIL_ANGLE, 16'd255);
        write_reg(CFG_STEP_TIME, 16'd0);
        write_reg(CFG_PAUSE_MS, 16'd0);
        queue_cmd(CMD_START, 8'd2);
        queue_ticks(4 * SETTLE_MS + 3);
        wait_results_drained();

        // lift angle and step time changed in the middle of the sweep
        write_reg(CFG_LIFT_ANGLE, 16'd10);
        write_reg(CFG_TAIL_ANGLE, 16'd0);
        write_reg(CFG_PAUSE_MS, 16'd5);
        queue_cmd(CMD_START, 8'd1);
        queue_ticks(SETTLE_MS + 4);
        wait_results_drained();
        write_reg(CFG_LIFT_ANGLE, 16'd0);
        write_reg(CFG_STEP_TIME, 16'd3);
        queue_ticks(SETTLE_MS + 30);
        wait_results_drained();

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    lift = 40;  tail = 40;  step = 17;  pause = 0;
                    send_idle_pct = 0;  recv_stall_pct = 0;  cnt_hi = 255;
                end
                1: begin
                    lift = 255; tail = 250; step = 1;   pause = 7;
                    send_idle_pct = 47; recv_stall_pct = 0;  cnt_hi = 255;
                end
                2: begin
                    lift = 0;   tail = 3;   step = 2;   pause = 1;
                    send_idle_pct = 0;  recv_stall_pct = 47; cnt_hi = 255;
                end
                default: begin
                    // longest step and pause; single strikes keep the pause out of reach
                    lift = 1;   tail = 0;   step = 255; pause = 65535;
                    send_idle_pct = 18; recv_stall_pct = 18; cnt_hi = 1;
                end
            endcase
            write_reg(CFG_LIFT_ANGLE, 16'(lift));
            write_reg(CFG_TAIL_ANGLE, 16'(tail));
            write_reg(CFG_STEP_TIME, 16'(step));
            write_reg(CFG_PAUSE_MS, 16'(pause));
            // the receiver holds off while the sender keeps offering
            if (p == 0) hold_trigger = ~hold_trigger;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                r = $urandom_range(99, 0);
                if (r < 12) begin
                    // noise burst of random ticks and starts
                    n = $urandom_range(24, 8);
                    repeat (n) queue_cmd(1'($urandom_range(1, 0)), 8'($urandom_range(cnt_hi, 0)));
                    phase_items += n;
                end else begin
                    // well-formed sequence: a start, then ticks to the end of its last strike
                    if (cnt_hi < 2) begin
                        cnt = $urandom_range(cnt_hi, 0);
                    end else begin
                        r = $urandom_range(99, 0);
                        if (r < 55) cnt = $urandom_range(3, 1);
                        else if (r < 70) cnt = $urandom_range(MAX_STRIKES, 4);
                        else if (r < 80) cnt = 0;
                        else cnt = $urandom_range(255, MAX_STRIKES + 1);
                    end
                    n = (cnt == 0) ? 1 : ((cnt > MAX_STRIKES) ? MAX_STRIKES : cnt);
                    d = (lift > tail) ? lift - tail : tail - lift;
                    s = (step == 0) ? 1 : step;
                    ticks = n * (2 * SETTLE_MS + d * s) + (n - 1) * pause;
                    // long sequences and a few others are cut short
                    if (ticks > SEQ_CAP || $urandom_range(99, 0) < 6)
                        ticks = $urandom_range((ticks > SEQ_CAP) ? SEQ_CAP : ticks, 1);
                    queue_cmd(CMD_START, 8'(cnt));
                    repeat (ticks) begin
                        queue_cmd(CMD_TICK, 8'($urandom_range(255, 0)));
                        if ($urandom_range(99, 0) < 2)
                            queue_cmd(CMD_START, 8'($urandom_range(255, 0)));
                    end
                    queue_ticks($urandom_range(4, 0));
                    phase_items += ticks + 1;
                    if ($urandom_range(99, 0) < 4) wait_results_drained();
                end
            end
            wait_results_drained();
        end

        if (mismatch_count == 0) begin
            $display("servo_strike_sequencer test passed");
        end else begin
            $display("servo_strike_sequencer test failed");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #3_000_000;
        $display("servo_strike_sequencer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sss_pkg.sv
src/sss_cfg_regs.sv
src/sss_core.sv
src/servo_strike_sequencer.sv
tb/testbench.sv
